### hw/rtl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

	// Calibration register indexes on the write port
	typedef enum logic [2:0] {
		REG_SENS          = 3'd0,
		REG_OFFSET        = 3'd1,
		REG_SENS_TEMP     = 3'd2,
		REG_OFFSET_TEMP   = 3'd3,
		REG_REF_TEMP      = 3'd4,
		REG_TEMP_COEFF    = 3'd5
	} bpc_reg_t;

	localparam int CAL_W   = 16;
	localparam int RAW_W   = 24;
	localparam int TEMP_W  = 19;
	localparam int OFS_W   = 40;   // offset / sensitivity, corrections included
	localparam int SQ_W    = 36;   // squared temperature distances
	localparam int PRESS_W = 32;

	// 20.00 C reference, and distance from it to -15.00 C
	localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] COLD_OFS = 19'sd3500;

	typedef struct packed {
		logic [CAL_W-1:0] c1;
		logic [CAL_W-1:0] c2;
		logic [CAL_W-1:0] c3;
		logic [CAL_W-1:0] c4;
		logic [CAL_W-1:0] c5;
		logic [CAL_W-1:0] c6;
	} bpc_cal_t;

	// First-order results
	typedef struct packed {
		logic        [RAW_W-1:0]  d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [TEMP_W-1:0] tdiff;  // temp - 20.00 C
		logic signed [TEMP_W-1:0] tcold;  // temp + 15.00 C
		logic signed [OFS_W-1:0]  off;
		logic signed [OFS_W-1:0]  sens;
	} bpc_first_t;

	// Corrected offset and sensitivity
	typedef struct packed {
		logic        [RAW_W-1:0]  d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFS_W-1:0]  off;
		logic signed [OFS_W-1:0]  sens;
	} bpc_corr_t;

endpackage

### hw/rtl/bpc_front.sv
`timescale 1ns / 1ps

module bpc_front
	import bpc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  bpc_cal_t                cal,
	input  logic                    v_in,
	input  logic [RAW_W-1:0]        d1_in,
	input  logic [RAW_W-1:0]        d2_in,
	output logic                    v_out,
	output bpc_first_t              dout
);

	logic                    v_s1, v_s2, v_s3;
	logic [RAW_W-1:0]        d1_s1, d1_s2;
	logic signed [RAW_W:0]   dt_s1;
	logic signed [41:0]      mt_s2, mo_s2, ms_s2;
	bpc_first_t              res_s3;

	logic signed [RAW_W:0]   dt_w;
	logic signed [TEMP_W-1:0] tdiff_w;
	logic signed [OFS_W-1:0] off_w, sens_w;

	// temperature difference dT = D2 - C5*2^8
	assign dt_w = $signed({1'b0, d2_in}) - $signed({1'b0, cal.c5, 8'b0});

	// first-order sums, shifts taken as slices of the products
	assign tdiff_w = mt_s2[41:23];
	assign off_w   = $signed({8'b0, cal.c2, 16'b0})
	               + {{5{mo_s2[41]}}, mo_s2[41:7]};
	assign sens_w  = $signed({9'b0, cal.c1, 15'b0})
	               + {{6{ms_s2[41]}}, ms_s2[41:8]};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1 <= d1_in;
			dt_s1 <= dt_w;

			d1_s2 <= d1_s1;
			mt_s2 <= dt_s1 * $signed({1'b0, cal.c6});
			mo_s2 <= dt_s1 * $signed({1'b0, cal.c4});
			ms_s2 <= dt_s1 * $signed({1'b0, cal.c3});

			res_s3.d1    <= d1_s2;
			res_s3.tdiff <= tdiff_w;
			res_s3.temp  <= tdiff_w + TEMP_REF;
			res_s3.tcold <= tdiff_w + COLD_OFS;
			res_s3.off   <= off_w;
			res_s3.sens  <= sens_w;
		end
	end

	assign v_out = v_s3;
	assign dout  = res_s3;

endmodule

### hw/rtl/bpc_corr.sv
`timescale 1ns / 1ps

module bpc_corr
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  bpc_first_t  din,
	output logic        v_out,
	output bpc_corr_t   dout
);

	logic               v_s4, v_s5, v_s6;
	bpc_first_t         fo_s4, fo_s5;
	logic               cold_s4, vcold_s4;
	logic [SQ_W-1:0]    lo_s4, vlo_s4;
	logic [OFS_W-1:0]   off2_s5, sens2_s5;
	bpc_corr_t          res_s6;

	logic signed [2*TEMP_W-1:0] sq_w, vsq_w;
	logic [OFS_W-1:0]   lo5_w, vlo7_w, vlo11_w, off2_w, sens2_w;

	assign sq_w  = din.tdiff * din.tdiff;
	assign vsq_w = din.tcold * din.tcold;

	// 5*lo, 7*vlo and 11*vlo as shift-and-add
	assign lo5_w   = {4'b0, lo_s4} + {2'b0, lo_s4, 2'b0};
	assign vlo7_w  = {1'b0, vlo_s4, 3'b0} - {4'b0, vlo_s4};
	assign vlo11_w = {1'b0, vlo_s4, 3'b0} + {3'b0, vlo_s4, 1'b0} + {4'b0, vlo_s4};

	// second-order terms, zero above 20.00 C, extra term below -15.00 C
	always_comb begin
		off2_w  = '0;
		sens2_w = '0;
		if (cold_s4) begin
			off2_w  = lo5_w >> 1;
			sens2_w = lo5_w >> 2;
			if (vcold_s4) begin
				off2_w  = off2_w + vlo7_w;
				sens2_w = sens2_w + (vlo11_w >> 1);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			fo_s4    <= din;
			cold_s4  <= din.tdiff[TEMP_W-1];
			vcold_s4 <= din.tcold[TEMP_W-1];
			lo_s4    <= sq_w[SQ_W-1:0];
			vlo_s4   <= vsq_w[SQ_W-1:0];

			fo_s5    <= fo_s4;
			off2_s5  <= off2_w;
			sens2_s5 <= sens2_w;

			res_s6.d1   <= fo_s5.d1;
			res_s6.temp <= fo_s5.temp;
			res_s6.off  <= fo_s5.off - $signed(off2_s5);
			res_s6.sens <= fo_s5.sens - $signed(sens2_s5);
		end
	end

	assign v_out = v_s6;
	assign dout  = res_s6;

endmodule

### hw/rtl/bpc_press.sv
`timescale 1ns / 1ps

module bpc_press
	import bpc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     v_in,
	input  bpc_corr_t                din,
	output logic                     v_out,
	output logic signed [PRESS_W-1:0] press,
	output logic signed [TEMP_W-1:0]  temp
);

	logic                     v_s7, v_s8, v_s9;
	logic [43:0]              pplo_s7;
	logic signed [44:0]       pphi_s7;
	logic signed [OFS_W-1:0]  off_s7, off_s8;
	logic signed [TEMP_W-1:0] temp_s7, temp_s8, temp_s9;
	logic signed [63:0]       prod_s8;
	logic signed [PRESS_W-1:0] press_s9;

	logic signed [43:0]       diff_w;

	// (D1*SENS/2^21 - OFF) / 2^15
	assign diff_w = {prod_s8[63], prod_s8[63:21]} - {{4{off_s8[OFS_W-1]}}, off_s8};

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_in;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// D1*SENS split into two 24x20 partial products, then joined
	always_ff @(posedge clk) begin
		if (en) begin
			pplo_s7 <= din.d1 * din.sens[19:0];
			pphi_s7 <= $signed({1'b0, din.d1}) * $signed(din.sens[OFS_W-1:20]);
			off_s7  <= din.off;
			temp_s7 <= din.temp;

			prod_s8 <= $signed({pphi_s7[43:0], 20'b0}) + $signed({20'b0, pplo_s7});
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;

			press_s9 <= {{3{diff_w[43]}}, diff_w[43:15]};
			temp_s9  <= temp_s8;
		end
	end

	assign v_out = v_s9;
	assign press = press_s9;
	assign temp  = temp_s9;

endmodule

### hw/rtl/baro_pressure_compensation.sv
// Nine-stage pipeline: a result is presented from the last stage, s9, once its input beat has passed all stages.
// Throughput is one beat per cycle; the pipeline moves as a whole and halts only
// when the output register holds a beat that is stalled.
// Reset clears all valid bits and the six calibration words to zero.
`timescale 1ns / 1ps

module baro_pressure_compensation
	import bpc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [2:0]                cfg_idx,
	input  logic [CAL_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [RAW_W-1:0]          raw_pressure,
	input  logic [RAW_W-1:0]          raw_temperature,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [PRESS_W-1:0] pressure,
	output logic signed [TEMP_W-1:0]  temperature
);

	bpc_cal_t    cal_q;
	logic        en;
	logic        v_first, v_corr;
	bpc_first_t  first;
	bpc_corr_t   corr;

	// pipeline advances unless the output beat is held
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// calibration words; out-of-range indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_SENS:        cal_q.c1 <= cfg_wdata;
				REG_OFFSET:      cal_q.c2 <= cfg_wdata;
				REG_SENS_TEMP:   cal_q.c3 <= cfg_wdata;
				REG_OFFSET_TEMP: cal_q.c4 <= cfg_wdata;
				REG_REF_TEMP:    cal_q.c5 <= cfg_wdata;
				REG_TEMP_COEFF:  cal_q.c6 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bpc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cal    (cal_q),
		.v_in   (in_valid),
		.d1_in  (raw_pressure),
		.d2_in  (raw_temperature),
		.v_out  (v_first),
		.dout   (first)
	);

	bpc_corr u_corr (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_first),
		.din    (first),
		.v_out  (v_corr),
		.dout   (corr)
	);

	bpc_press u_press (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_corr),
		.din    (corr),
		.v_out  (out_valid),
		.press  (pressure),
		.temp   (temperature)
	);

endmodule

### verif/bpc_checker.sv
`timescale 1ns / 1ps

module bpc_checker
	import bpc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [2:0]                cfg_idx,
	input  logic [CAL_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [RAW_W-1:0]          raw_pressure,
	input  logic [RAW_W-1:0]          raw_temperature,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic signed [PRESS_W-1:0] pressure,
	input  logic signed [TEMP_W-1:0]  temperature,
	output int                        bad_readings,
	output int                        readings_due
);

	localparam int     REPORT_LIMIT  = 10;
	localparam longint TEMP_REF_CENT = 2000;   // 20.00 C
	localparam longint COLD_CENT     = -1500;  // -15.00 C

	typedef struct packed {
		logic signed [PRESS_W-1:0] pressure;
		logic signed [TEMP_W-1:0]  temperature;
	} reading_t;

	bpc_cal_t cal = '0;
	reading_t due_readings[$];
	int       errors = 0;

	// Second-order compensation on exact 64-bit values; >>> rounds toward minus infinity
	function automatic reading_t compensate(bpc_cal_t k, logic [RAW_W-1:0] d1,
			logic [RAW_W-1:0] d2);
		longint   dt, temp, off, sens, warm_sq, cold, p;
		reading_t r;
		dt   = longint'(d2) - longint'(k.c5) * 256;
		temp = TEMP_REF_CENT + ((dt * longint'(k.c6)) >>> 23);
		off  = longint'(k.c2) * 65536 + ((longint'(k.c4) * dt) >>> 7);
		sens = longint'(k.c1) * 32768 + ((longint'(k.c3) * dt) >>> 8);
		// below 20.00 C both terms are pulled down
		if (temp < TEMP_REF_CENT) begin
			warm_sq = (temp - TEMP_REF_CENT) * (temp - TEMP_REF_CENT);
			off  -= (5 * warm_sq) >>> 1;
			sens -= (5 * warm_sq) >>> 2;
			// and further below -15.00 C
			if (temp < COLD_CENT) begin
				cold = (temp - COLD_CENT) * (temp - COLD_CENT);
				off  -= 7 * cold;
				sens -= (11 * cold) >>> 1;
			end
		end
		p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
		r.pressure    = p[PRESS_W-1:0];
		r.temperature = temp[TEMP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			cal = '0;
			due_readings.delete();
		end else begin
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (due_readings.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("[%0t] reading with none due: pressure %0d temperature %0d",
							$time, pressure, temperature);
				end else begin
					want = due_readings.pop_front();
					if (pressure !== want.pressure || temperature !== want.temperature) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("[%0t] pressure exp %0d got %0d, temperature exp %0d got %0d",
								$time, want.pressure, pressure, want.temperature, temperature);
					end
				end
			end
			// input beat
			if (in_valid && !in_stall)
				due_readings.push_back(compensate(cal, raw_pressure, raw_temperature));
			// calibration write; unused indexes fall through
			if (cfg_wen) begin
				case (cfg_idx)
					REG_SENS:        cal.c1 = cfg_wdata;
					REG_OFFSET:      cal.c2 = cfg_wdata;
					REG_SENS_TEMP:   cal.c3 = cfg_wdata;
					REG_OFFSET_TEMP: cal.c4 = cfg_wdata;
					REG_REF_TEMP:    cal.c5 = cfg_wdata;
					REG_TEMP_COEFF:  cal.c6 = cfg_wdata;
					default: ;
				endcase
			end
		end
		bad_readings <= errors;
		readings_due <= due_readings.size();
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bpc_pkg::*;

	localparam int     RESET_CYCLES    = 9;
	localparam int     WATCHDOG_LIMIT  = 2000;
	localparam int     SETTLE_CYCLES   = 20;
	localparam int     SQUEEZE_CYCLES  = 80;
	localparam int     IDLE_PERCENT    = 33;
	localparam int     PHASES          = 8;
	localparam int     STEADY_PHASE    = 4;
	localparam int     BEATS_PER_PHASE = 220;
	localparam longint TEMP_REF_CENT   = 2000;
	localparam longint COLD_CENT       = -1500;

	// indexes beyond the last calibration word
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [RAW_W-1:0] RAW_MAX = '1;

	localparam bpc_cal_t TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
		c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wen;
	logic [2:0]                cfg_idx;
	logic [CAL_W-1:0]          cfg_wdata;
	logic                      in_valid;
	logic                      in_stall;
	logic [RAW_W-1:0]          raw_pressure;
	logic [RAW_W-1:0]          raw_temperature;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [PRESS_W-1:0] pressure;
	logic signed [TEMP_W-1:0]  temperature;

	int       bad_readings;
	int       readings_due;
	int       quiet_cycles = 0;
	bit       steady = 1'b0;
	bit       squeeze_pending = 1'b0;
	bpc_cal_t cal_now = '0;

	baro_pressure_compensation DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pressure        (pressure),
		.temperature     (temperature)
	);

	bpc_checker reading_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pressure        (pressure),
		.temperature     (temperature),
		.bad_readings    (bad_readings),
		.readings_due    (readings_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: too long without any beat or register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen)
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_pending) begin
				// long enough for the pipeline to fill and stall its input
				squeeze_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else
				out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	function automatic logic [RAW_W-1:0] clip_raw(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(RAW_MAX))
			return RAW_MAX;
		return v[RAW_W-1:0];
	endfunction

	// Smallest raw temperature that lands on the target under the current calibration
	function automatic logic [RAW_W-1:0] raw_for_temp(longint target);
		longint want, step;
		if (cal_now.c6 == 0)
			return clip_raw(longint'(cal_now.c5) * 256);
		want = (target - TEMP_REF_CENT) * (longint'(1) << 23);
		step = want / longint'(cal_now.c6);
		if (step * longint'(cal_now.c6) < want)
			step++;
		return clip_raw(longint'(cal_now.c5) * 256 + step);
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [CAL_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic program_cal(bpc_cal_t k);
		write_reg(REG_SENS, k.c1);
		write_reg(REG_OFFSET, k.c2);
		write_reg(REG_SENS_TEMP, k.c3);
		write_reg(REG_OFFSET_TEMP, k.c4);
		write_reg(REG_REF_TEMP, k.c5);
		write_reg(REG_TEMP_COEFF, k.c6);
		cfg_wen <= 1'b0;
		cal_now = k;
	endtask

	// One conversion pair, with a random gap in front of it
	task automatic send_beat(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		raw_pressure    <= d1;
		raw_temperature <= d2;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_readings();
		in_valid <= 1'b0;
		@(posedge clk);
		while (readings_due != 0)
			@(posedge clk);
	endtask

	// Mostly full-range pairs, with weight near 20.00 C, near -15.00 C and at the ends
	task automatic random_beat();
		logic [RAW_W-1:0] d1, d2;
		int               roll;
		d1   = RAW_W'($urandom());
		roll = $urandom_range(99);
		if (roll < 5)
			d1 = '0;
		else if (roll < 10)
			d1 = RAW_MAX;
		roll = $urandom_range(99);
		if (roll < 55)
			d2 = RAW_W'($urandom());
		else if (roll < 75)
			d2 = clip_raw(longint'(cal_now.c5) * 256 + longint'($urandom_range(4096)) - 2048);
		else if (roll < 95)
			d2 = clip_raw(longint'(raw_for_temp(COLD_CENT)) +
				longint'($urandom_range(4096)) - 2048);
		else
			d2 = roll[0] ? RAW_MAX : '0;
		send_beat(d1, d2);
	endtask

	initial begin
		bpc_cal_t k;
		arst_n          <= 1'b0;
		cfg_wen         <= 1'b0;
		cfg_idx         <= '0;
		cfg_wdata       <= '0;
		in_valid        <= 1'b0;
		raw_pressure    <= '0;
		raw_temperature <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration still at reset: every reading is 20.00 C and zero pressure
		repeat (6)
			send_beat(RAW_W'($urandom()), RAW_W'($urandom()));
		drain_readings();

		// writes to unused indexes must not land anywhere
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, 16'hA5C3);
		cfg_wen <= 1'b0;
		send_beat(RAW_MAX, RAW_MAX);
		send_beat('0, '0);
		drain_readings();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: k = TYPICAL_CAL;
				1: k = '1;
				2: k = '0;
				default: k = bpc_cal_t'({$urandom(), $urandom(), $urandom()});
			endcase
			program_cal(k);

			// either side of 20.00 C and -15.00 C
			if (ph == 0) begin
				send_beat('0, raw_for_temp(TEMP_REF_CENT));
				send_beat(RAW_MAX, raw_for_temp(TEMP_REF_CENT));
				send_beat(RAW_MAX, raw_for_temp(TEMP_REF_CENT - 1));
				send_beat(RAW_W'($urandom()), raw_for_temp(TEMP_REF_CENT + 1));
				send_beat(RAW_W'($urandom()), raw_for_temp(COLD_CENT));
				send_beat(RAW_MAX, raw_for_temp(COLD_CENT - 1));
				send_beat('0, raw_for_temp(COLD_CENT - 1));
				send_beat(RAW_W'($urandom()), raw_for_temp(COLD_CENT + 1));
			end
			// raw extremes, the coldest reading included
			if (ph <= 1) begin
				send_beat('0, '0);
				send_beat(RAW_MAX, '0);
				send_beat('0, RAW_MAX);
				send_beat(RAW_MAX, RAW_MAX);
			end

			steady          = (ph == STEADY_PHASE);
			squeeze_pending = steady;
			repeat (BEATS_PER_PHASE)
				random_beat();
			drain_readings();
			steady = 1'b0;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bad_readings == 0 && readings_due == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### baro_pressure_compensation.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_front.sv
hw/rtl/bpc_corr.sv
hw/rtl/bpc_press.sv
hw/rtl/baro_pressure_compensation.sv
verif/bpc_checker.sv
verif/testbench.sv
